@@ hw/rtl/srfc_pkg.sv @@
// shared types and constants for the sensor reply frame checker
package srfc_pkg;

  localparam logic [7:0]  HDR_BYTE0   = 8'hEF;
  localparam logic [7:0]  HDR_BYTE1   = 8'h01;
  localparam logic [7:0]  HDR_FILL    = 8'hFF;
  localparam int          HDR_LEN     = 6;
  localparam int          PRE_LEN     = 10;
  localparam int          FRAME_OVHD  = 12;
  localparam int          SUM_OFFSET  = 7;
  localparam logic [15:0] MIN_LEN     = 16'd3;
  localparam int          CNT_W       = 17;
  localparam int          LEN_W       = 16;
  localparam int          OUT_DATA_W  = 32;
  localparam int          OUT_USER_W  = 2;

  localparam logic [3:0] POS_PID    = 4'd6;
  localparam logic [3:0] POS_LEN_HI = 4'd7;
  localparam logic [3:0] POS_LEN_LO = 4'd8;

  typedef enum logic [1:0] {
    VERDICT_GOOD = 2'd0,
    VERDICT_CSUM = 2'd1,
    VERDICT_HDR  = 2'd2,
    VERDICT_LEN  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       verdict_valid;
    verdict_t   verdict;
    logic [7:0] confirm_code;
    logic [7:0] package_id;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic             frame_ended;
    logic             verdict_given;
  } status_t;

endpackage

@@ hw/rtl/sensor_reply_frame_checker.sv @@
// top level: input word register, frame receiver core and output register
// path: an accepted in_ word is held in the input register, then its result in the output register
// throughput: one word per cycle while out_ does not stall, as the core updates its state once per word
// stalls on out_ back up through the input register to in_tready
// rst_n is synchronous, active low; it clears the receiver and the register
// restart words clear the receiver but keep expected_payload_length
module sensor_reply_frame_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // rx_byte
  input  logic                            in_tuser,   // restart
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [srfc_pkg::OUT_DATA_W-1:0] out_tdata,  // payload_byte, verdict,
                                                      // confirm_code, package_id
  output logic [srfc_pkg::OUT_USER_W-1:0] out_tuser,  // payload_valid, verdict_valid
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [15:0]                     cfg_data    // expected_payload_length
);
  import srfc_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_restart_r;
  logic       s1_adv;
  logic [15:0] exp_len_r;
  result_t    res;
  result_t    out_res_r;
  status_t    status;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= '0;
    end else if (cfg_valid) begin
      exp_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r    <= in_tdata;
      s1_restart_r <= in_tuser;
    end
  end

  srfc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .rx_byte (s1_byte_r),
    .restart (s1_restart_r),
    .exp_len (exp_len_r),
    .res     (res),
    .status  (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (!out_tvalid || out_tready) begin
      out_tvalid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tdata = {6'd0, out_res_r.package_id, out_res_r.confirm_code,
                      out_res_r.verdict, out_res_r.payload_byte};
  assign out_tuser = {out_res_r.verdict_valid, out_res_r.payload_valid};

`ifndef SYNTHESIS
  a_pay_ver_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("payload and verdict on the same word");

  a_conf_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[9:8] != VERDICT_GOOD) |-> (out_tdata[17:10] == 8'd0))
    else $error("confirm code on a failed verdict");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_restart_r) |=> (status.byte_count == '0 && !status.verdict_given))
    else $error("restart did not clear the receiver");

  a_verdict_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res.verdict_valid) |=> (status.frame_ended && status.verdict_given))
    else $error("verdict without frame end");
`endif

endmodule

@@ hw/rtl/srfc_core.sv @@
// frame receiver state and per-word decode logic
module srfc_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic [7:0]                rx_byte,
  input  logic                      restart,
  input  logic [15:0]               exp_len,
  output srfc_pkg::result_t         res,
  output srfc_pkg::status_t         status
);
  import srfc_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [15:0]      rsum_r, rsum_nxt;
  logic [7:0]       conf_r, conf_nxt;
  logic [7:0]       pid_r, pid_nxt;
  verdict_t         verd_r, verd_nxt;
  logic             ended_r, ended_nxt;
  logic             given_r, given_nxt;

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] sum_hi_pos;
  logic [CNT_W-1:0] need_cnt;
  logic [7:0]       want;
  logic [15:0]      len_full;
  logic [15:0]      rsum_full;

  assign sum_hi_pos = {1'b0, len_r} + CNT_W'(SUM_OFFSET);
  assign need_cnt   = {1'b0, exp_len} + CNT_W'(FRAME_OVHD);
  assign pos        = cnt_r;
  assign len_full   = {len_r[15:8], rx_byte};
  assign rsum_full  = {rsum_r[15:8], rx_byte};

  always_comb begin
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    rsum_nxt  = rsum_r;
    conf_nxt  = conf_r;
    pid_nxt   = pid_r;
    verd_nxt  = verd_r;
    ended_nxt = ended_r;
    given_nxt = given_r;
    want      = HDR_FILL;
    res       = '0;

    if (restart) begin
      cnt_nxt   = '0;
      len_nxt   = '0;
      sum_nxt   = '0;
      rsum_nxt  = '0;
      conf_nxt  = '0;
      pid_nxt   = '0;
      verd_nxt  = VERDICT_GOOD;
      ended_nxt = 1'b0;
      given_nxt = 1'b0;
    end else begin
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (!ended_r) begin
        if (pos < CNT_W'(HDR_LEN)) begin
          if (pos == '0) begin
            want = HDR_BYTE0;
          end else if (pos == CNT_W'(1)) begin
            want = HDR_BYTE1;
          end
          if (rx_byte != want) begin
            ended_nxt = 1'b1;
            verd_nxt  = VERDICT_HDR;
          end
        end else if (pos < CNT_W'(PRE_LEN)) begin
          sum_nxt = sum_r + {8'd0, rx_byte};
          unique case (pos[3:0])
            POS_PID:    pid_nxt = rx_byte;
            POS_LEN_HI: len_nxt = {rx_byte, 8'd0};
            POS_LEN_LO: begin
              len_nxt = len_full;
              if (len_full < MIN_LEN) begin
                ended_nxt = 1'b1;
                verd_nxt  = VERDICT_LEN;
              end
            end
            default:    conf_nxt = rx_byte;
          endcase
        end else if (pos < sum_hi_pos) begin
          sum_nxt           = sum_r + {8'd0, rx_byte};
          res.payload_byte  = rx_byte;
          res.payload_valid = 1'b1;
        end else if (pos == sum_hi_pos) begin
          rsum_nxt = {rx_byte, 8'd0};
        end else begin
          rsum_nxt  = rsum_full;
          ended_nxt = 1'b1;
          verd_nxt  = (rsum_full == sum_r) ? VERDICT_GOOD : VERDICT_CSUM;
        end
      end
      if (ended_nxt && !given_r && (cnt_nxt >= need_cnt)) begin
        given_nxt         = 1'b1;
        res.verdict_valid = 1'b1;
        res.verdict       = verd_nxt;
        if (verd_nxt == VERDICT_GOOD) begin
          res.confirm_code = conf_nxt;
        end
      end
    end
    res.package_id = pid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      rsum_r  <= '0;
      conf_r  <= '0;
      pid_r   <= '0;
      verd_r  <= VERDICT_GOOD;
      ended_r <= 1'b0;
      given_r <= 1'b0;
    end else if (step_en) begin
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      rsum_r  <= rsum_nxt;
      conf_r  <= conf_nxt;
      pid_r   <= pid_nxt;
      verd_r  <= verd_nxt;
      ended_r <= ended_nxt;
      given_r <= given_nxt;
    end
  end

  assign status.byte_count    = cnt_r;
  assign status.frame_ended   = ended_r;
  assign status.verdict_given = given_r;

endmodule
